// ===== hdl/fdpri_pkg.sv =====
// ----------------------------------------------------------------------------
// fdpri_pkg: shared types and constants for the floppy phase register block
// Beat layouts, mode and command codes, per-drive state and the rpm zones.
// ----------------------------------------------------------------------------
package fdpri_pkg;

    // Default sizing of the drive side.
    localparam int DRIVES_DEF = 2;
    localparam int TRACKS_DEF = 80;

    // Field and register widths.
    localparam int TRACK_W = 7;
    localparam int RPM_W   = 10;
    localparam int TPS_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W = 16;
    localparam int TUSER_W = 3;

    // Reset value of the tick rate register.
    localparam logic [TPS_W-1:0] TPS_RESET = 16'd60000;

    // Bit positions on the phase lines.
    localparam int LINE_CA1    = 1;
    localparam int LINE_CA2    = 2;
    localparam int LINE_STROBE = 3;

    // Item kinds carried in tuser.
    typedef enum logic [2:0] {
        MODE_LINES  = 3'd0,
        MODE_ENABLE = 3'd1,
        MODE_SELECT = 3'd2,
        MODE_STATUS = 3'd3,
        MODE_MEDIA  = 3'd4,
        MODE_TICK   = 3'd5
    } t_mode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_S = 2'd2;

    // Enable mask codes.
    localparam logic [1:0] EN_DRIVE0 = 2'd1;
    localparam logic [1:0] EN_DRIVE1 = 2'd2;

    // Strobe commands, code is {CA1, CA0, SEL, CA2}.
    localparam logic [3:0] CMD_DIR_IN    = 4'h0;
    localparam logic [3:0] CMD_DIR_OUT   = 4'h1;
    localparam logic [3:0] CMD_CLR_SWTCH = 4'h3;
    localparam logic [3:0] CMD_STEP      = 4'h4;
    localparam logic [3:0] CMD_MOTOR_ON  = 4'h8;
    localparam logic [3:0] CMD_MOTOR_OFF = 4'h9;
    localparam logic [3:0] CMD_EJECT     = 4'hD;

    // Status read codes, same packing.
    localparam logic [3:0] ST_DIRECTION  = 4'h0;
    localparam logic [3:0] ST_HEAD_LOWER = 4'h1;
    localparam logic [3:0] ST_NO_DISK    = 4'h2;
    localparam logic [3:0] ST_HEAD_UPPER = 4'h3;
    localparam logic [3:0] ST_STEP_DONE  = 4'h4;
    localparam logic [3:0] ST_WR_ENABLED = 4'h6;
    localparam logic [3:0] ST_MOTOR      = 4'h8;
    localparam logic [3:0] ST_TWO_SIDED  = 4'h9;
    localparam logic [3:0] ST_NOT_TRK0   = 4'hA;
    localparam logic [3:0] ST_ZERO_B     = 4'hB;
    localparam logic [3:0] ST_SWITCHED   = 4'hC;
    localparam logic [3:0] ST_ZERO_D     = 4'hD;
    localparam logic [3:0] ST_TACH       = 4'hE;
    localparam logic [3:0] ST_ZERO_F     = 4'hF;

    // Configuration registers as seen by the core.
    typedef struct packed {
        logic               ext_speed;
        logic [RPM_W-1:0]   speed_value;
        logic [TPS_W-1:0]   ticks_per_sec;
    } t_cfg;

    // Input item payload, last field in the lowest bits.
    typedef struct packed {
        logic               media_ds;
        logic               media_wp;
        logic               media_inserted;
        logic               media_drive;
        logic               select_level;
        logic [1:0]         en_code;
        logic [3:0]         line_bits;
    } t_item;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic               reload_track;
        logic               drive_chosen;
        logic               drive_on;
        logic               head_now;
        logic [TRACK_W-1:0] track_now;
        logic               status_bit;
    } t_result;

    // State held for each drive.
    typedef struct packed {
        logic               step_out;
        logic               upper_head;
        logic               switched;
        logic               motor;
        logic [TRACK_W-1:0] track;
        logic               present;
        logic               protect;
        logic               two_sided;
    } t_drive;

    // Rotation speed of a track zone, sixteen tracks a zone.
    function automatic logic [RPM_W-1:0] zone_rpm(input logic [TRACK_W-1:0] track);
        logic [RPM_W-1:0] rpm;
        case (track[TRACK_W-1:4])
            3'd0:    rpm = 10'd500;
            3'd1:    rpm = 10'd550;
            3'd2:    rpm = 10'd600;
            3'd3:    rpm = 10'd675;
            default: rpm = 10'd750;
        endcase
        return rpm;
    endfunction

endpackage

// ===== hdl/fdpri_core.sv =====
// ----------------------------------------------------------------------------
// fdpri_core: drive state and combinational item decode
// Holds the phase lines, per-drive state and tachometer, and forms the result
// of an accepted item from the current state in the same cycle.
// ----------------------------------------------------------------------------
module fdpri_core #(
    parameter int DRIVES = fdpri_pkg::DRIVES_DEF,
    parameter int TRACKS = fdpri_pkg::TRACKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  fdpri_pkg::t_mode    i_mode,
    input  fdpri_pkg::t_item    i_item,
    input  fdpri_pkg::t_cfg     i_cfg,
    output fdpri_pkg::t_result  o_result
);

    localparam logic [fdpri_pkg::TRACK_W-1:0] TRACK_MAX = fdpri_pkg::TRACK_W'(TRACKS - 1);

    logic [3:0]          r_line, n_line;
    logic                r_en, n_en;
    logic                r_chosen, n_chosen;
    logic                r_sel, n_sel;
    logic [fdpri_pkg::TPS_W-1:0] r_acc, n_acc;
    logic                r_phase, n_phase;
    fdpri_pkg::t_drive   r_drv [DRIVES];
    fdpri_pkg::t_drive   n_drv [DRIVES];

    fdpri_pkg::t_drive   cur;
    fdpri_pkg::t_drive   nd;
    fdpri_pkg::t_drive   out_drv;
    logic                nd_wr;
    logic                status;
    logic                reload;
    logic [3:0]          cmd_code;
    logic [3:0]          st_code;
    logic [fdpri_pkg::RPM_W-1:0] rpm;
    logic [fdpri_pkg::TPS_W:0]   acc_sum;
    logic [fdpri_pkg::TPS_W:0]   tps_ext;

    // State registers; every piece of state clears on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= '0;
            r_en     <= 1'b0;
            r_chosen <= 1'b0;
            r_sel    <= 1'b0;
            r_acc    <= '0;
            r_phase  <= 1'b0;
            for (int k = 0; k < DRIVES; k++) begin
                r_drv[k] <= '0;
            end
        end else begin
            r_line   <= n_line;
            r_en     <= n_en;
            r_chosen <= n_chosen;
            r_sel    <= n_sel;
            r_acc    <= n_acc;
            r_phase  <= n_phase;
            r_drv    <= n_drv;
        end
    end

    // Item decode and next state.
    always_comb begin
        n_line   = r_line;
        n_en     = r_en;
        n_chosen = r_chosen;
        n_sel    = r_sel;
        n_acc    = r_acc;
        n_phase  = r_phase;
        n_drv    = r_drv;
        status   = 1'b1;
        reload   = 1'b0;
        nd_wr    = 1'b0;

        // State of the drive currently selected.
        cur = '0;
        for (int k = 0; k < DRIVES; k++) begin
            if (k == int'(r_chosen)) begin
                cur = r_drv[k];
            end
        end
        nd = cur;

        // A strobe command sees the new lines; a status read sees the held ones.
        cmd_code = {i_item.line_bits[1:0], r_sel, i_item.line_bits[fdpri_pkg::LINE_CA2]};
        st_code  = {r_line[1:0], r_sel, r_line[fdpri_pkg::LINE_CA2]};

        // Tachometer step: twice the rpm, one wrap against the tick rate.
        if (i_cfg.ext_speed) begin
            rpm = i_cfg.speed_value;
        end else if (!cur.present) begin
            rpm = '0;
        end else begin
            rpm = fdpri_pkg::zone_rpm(cur.track);
        end
        acc_sum = {1'b0, r_acc} + {6'b0, rpm, 1'b0};
        tps_ext = {1'b0, i_cfg.ticks_per_sec};

        if (i_accept) begin
            case (i_mode)
                fdpri_pkg::MODE_LINES: begin
                    n_line = i_item.line_bits;
                    if (i_item.line_bits[fdpri_pkg::LINE_STROBE] &&
                        !r_line[fdpri_pkg::LINE_STROBE] && r_en) begin
                        nd_wr = 1'b1;
                        case (cmd_code)
                            fdpri_pkg::CMD_DIR_IN:    nd.step_out = 1'b0;
                            fdpri_pkg::CMD_DIR_OUT:   nd.step_out = 1'b1;
                            fdpri_pkg::CMD_CLR_SWTCH: nd.switched = 1'b0;
                            fdpri_pkg::CMD_STEP: begin
                                if (cur.present) begin
                                    if (cur.step_out) begin
                                        if (cur.track != '0) begin
                                            nd.track = cur.track - 1'b1;
                                        end
                                    end else if (cur.track < TRACK_MAX) begin
                                        nd.track = cur.track + 1'b1;
                                    end
                                    reload = 1'b1;
                                end
                            end
                            fdpri_pkg::CMD_MOTOR_ON: begin
                                if (cur.present) nd.motor = 1'b1;
                            end
                            fdpri_pkg::CMD_MOTOR_OFF: begin
                                if (cur.present) nd.motor = 1'b0;
                            end
                            fdpri_pkg::CMD_EJECT: begin
                                if (cur.present) begin
                                    nd     = '0;
                                    reload = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                fdpri_pkg::MODE_ENABLE: begin
                    if (i_item.en_code == fdpri_pkg::EN_DRIVE0) begin
                        n_en     = 1'b1;
                        n_chosen = 1'b0;
                    end else if (i_item.en_code == fdpri_pkg::EN_DRIVE1 && DRIVES >= 2) begin
                        n_en     = 1'b1;
                        n_chosen = 1'b1;
                    end else begin
                        n_en = 1'b0;
                    end
                end
                fdpri_pkg::MODE_SELECT: begin
                    n_sel = i_item.select_level;
                end
                fdpri_pkg::MODE_STATUS: begin
                    // CA1 with strobe high, or no drive enabled, reads as one.
                    if ((r_line[fdpri_pkg::LINE_CA1] && r_line[fdpri_pkg::LINE_STROBE]) ||
                        !r_en) begin
                        status = 1'b1;
                    end else begin
                        case (st_code)
                            fdpri_pkg::ST_DIRECTION:  status = cur.step_out;
                            fdpri_pkg::ST_HEAD_LOWER: begin
                                nd_wr         = 1'b1;
                                nd.upper_head = 1'b0;
                                reload        = cur.upper_head;
                                status        = 1'b0;
                            end
                            fdpri_pkg::ST_NO_DISK:    status = !cur.present;
                            fdpri_pkg::ST_HEAD_UPPER: begin
                                nd_wr         = 1'b1;
                                nd.upper_head = 1'b1;
                                reload        = !cur.upper_head;
                                status        = 1'b0;
                            end
                            fdpri_pkg::ST_STEP_DONE:  status = 1'b1;
                            fdpri_pkg::ST_WR_ENABLED: status = cur.present && !cur.protect;
                            fdpri_pkg::ST_MOTOR:      status = cur.present && cur.motor;
                            fdpri_pkg::ST_TWO_SIDED:  status = !cur.present || cur.two_sided;
                            fdpri_pkg::ST_NOT_TRK0:   status = cur.present && (cur.track != '0);
                            fdpri_pkg::ST_ZERO_B:     status = 1'b0;
                            fdpri_pkg::ST_SWITCHED:   status = cur.switched;
                            fdpri_pkg::ST_ZERO_D:     status = 1'b0;
                            fdpri_pkg::ST_TACH:       status = r_phase;
                            fdpri_pkg::ST_ZERO_F:     status = 1'b0;
                            default:                  status = 1'b1;
                        endcase
                    end
                end
                fdpri_pkg::MODE_MEDIA: begin
                    // Events for a drive that does not exist match no entry.
                    for (int k = 0; k < DRIVES; k++) begin
                        if (k == int'(i_item.media_drive)) begin
                            if (i_item.media_inserted) begin
                                n_drv[k].present   = 1'b1;
                                n_drv[k].protect   = i_item.media_wp;
                                n_drv[k].two_sided = i_item.media_ds;
                                n_drv[k].switched  = 1'b1;
                            end else begin
                                n_drv[k] = '0;
                            end
                            if (i_item.media_drive == r_chosen) begin
                                reload = 1'b1;
                            end
                        end
                    end
                end
                fdpri_pkg::MODE_TICK: begin
                    if (acc_sum >= tps_ext) begin
                        n_acc   = fdpri_pkg::TPS_W'(acc_sum - tps_ext);
                        n_phase = !r_phase;
                    end else begin
                        n_acc = acc_sum[fdpri_pkg::TPS_W-1:0];
                    end
                end
                default: ;
            endcase
        end

        // Write back the selected drive after a command or head switch.
        if (nd_wr) begin
            for (int k = 0; k < DRIVES; k++) begin
                if (k == int'(r_chosen)) begin
                    n_drv[k] = nd;
                end
            end
        end

        // Result reports the selected drive after the item.
        out_drv = '0;
        for (int k = 0; k < DRIVES; k++) begin
            if (k == int'(n_chosen)) begin
                out_drv = n_drv[k];
            end
        end
    end

    assign o_result.status_bit   = status;
    assign o_result.track_now    = out_drv.track;
    assign o_result.head_now     = out_drv.upper_head;
    assign o_result.drive_on     = n_en;
    assign o_result.drive_chosen = n_chosen;
    assign o_result.reload_track = reload;

endmodule

// ===== hdl/floppy_drive_phase_register_interface.sv =====
// ----------------------------------------------------------------------------
// floppy_drive_phase_register_interface: drive side of a two-drive interface
// Takes controller bus beats, keeps drive state and returns one result each.
// ----------------------------------------------------------------------------
// Usage
// The slave channel carries one bus access per beat: tuser holds the kind
// (set lines, set enable, set select, read status, media event, tick) and
// tdata the payload. Every accepted beat yields exactly one result beat on
// the master channel with the status bit, the selected drive's track and
// head, the enable state, the drive index and a track reload flag.
// The result is registered at the edge that accepts the beat, in the output
// register when that is free or else in the skid register behind it.
// Throughput is one beat per cycle while the receiver keeps up; the decode
// is a single pass of logic from the drive state to the result register.
// If the receiver stalls, one further beat is taken into a skid register,
// after which s_tready drops until the output drains.
// Reset clears all drive state, the tachometer and both output valid flags;
// the tick rate register returns to 60000 and the speed registers to zero.
// Configuration writes take effect on the edge at which i_cfg_wr_en is high.
// ----------------------------------------------------------------------------
module floppy_drive_phase_register_interface #(
    parameter int DRIVES = fdpri_pkg::DRIVES_DEF,
    parameter int TRACKS = fdpri_pkg::TRACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_wr_en,
    input  logic [fdpri_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [fdpri_pkg::CFG_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: line_bits[3:0], en_code[5:4], select_level[6],
    // media_drive[7], media_inserted[8], media_write_protect[9],
    // media_double_sided[10], zero fill above.
    input  logic [fdpri_pkg::TDATA_W-1:0]       s_tdata,
    // tuser: mode[2:0].
    input  logic [fdpri_pkg::TUSER_W-1:0]       s_tuser,
    // Output channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata from bit 0: status_bit[0], track_now[7:1], head_now[8],
    // drive_on[9], drive_chosen[10], reload_track[11], zero fill above.
    output logic [fdpri_pkg::TDATA_W-1:0]       m_tdata
);

    localparam int ITEM_W = $bits(fdpri_pkg::t_item);
    localparam int RES_W  = $bits(fdpri_pkg::t_result);

    fdpri_pkg::t_cfg     r_cfg;
    fdpri_pkg::t_item    item;
    fdpri_pkg::t_mode    mode;
    fdpri_pkg::t_result  result;
    fdpri_pkg::t_result  r_out;
    fdpri_pkg::t_result  r_skid;
    logic                r_out_vld;
    logic                r_skid_vld;
    logic                accept;
    logic                out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ext_speed     <= 1'b0;
            r_cfg.speed_value   <= '0;
            r_cfg.ticks_per_sec <= fdpri_pkg::TPS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                fdpri_pkg::CFG_EXT_SPEED:   r_cfg.ext_speed     <= i_cfg_wdata[0];
                fdpri_pkg::CFG_SPEED_VALUE: begin
                    r_cfg.speed_value <= i_cfg_wdata[fdpri_pkg::RPM_W-1:0];
                end
                fdpri_pkg::CFG_TICKS_PER_S: begin
                    r_cfg.ticks_per_sec <= i_cfg_wdata[fdpri_pkg::TPS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Beat unpacking and handshake.
    assign item     = fdpri_pkg::t_item'(s_tdata[ITEM_W-1:0]);
    assign mode     = fdpri_pkg::t_mode'(s_tuser);
    assign s_tready = !r_skid_vld;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_vld || m_tready;

    fdpri_core #(
        .DRIVES (DRIVES),
        .TRACKS (TRACKS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (mode),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register with one skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    // Payload of the output and skid registers.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : result;
        end
        if (!out_free && accept) begin
            r_skid <= result;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {{(fdpri_pkg::TDATA_W - RES_W){1'b0}}, r_out};

    // The skid register only fills behind a stalled output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a beat while the output is empty");

    // A reported track never passes the last track.
    a_track_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (int'(r_out.track_now) < TRACKS))
        else $error("track beyond the last track reported");

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_skid_vld))
        else $error("result beat pending after reset");

endmodule

// ===== sim/fdpri_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdpri_checker: result checker for the floppy phase register block
// Watches the configuration port and both stream channels, keeps its own
// copy of the drive state, predicts one result beat per accepted input beat
// and compares every result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fdpri_checker #(
    parameter int DRIVES = fdpri_pkg::DRIVES_DEF,
    parameter int TRACKS = fdpri_pkg::TRACKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fdpri_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fdpri_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // tdata from bit 0: line_bits, en_code, select_level, media_drive,
    // media_inserted, media_write_protect, media_double_sided.
    input  logic [fdpri_pkg::TDATA_W-1:0]   i_s_tdata,
    // tuser: mode.
    input  logic [fdpri_pkg::TUSER_W-1:0]   i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tdata from bit 0: status_bit, track_now, head_now, drive_on,
    // drive_chosen, reload_track.
    input  logic [fdpri_pkg::TDATA_W-1:0]   i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    import fdpri_pkg::*;

    // Shadow copy of the block's state and registers.
    logic [3:0]       lines_q;
    logic             enabled_q;
    logic             chosen_q;
    logic             select_q;
    t_drive           drive_q [2];
    logic [TPS_W-1:0] tach_acc_q;
    logic             tach_phase_q;
    logic             ext_speed_q;
    logic [RPM_W-1:0] speed_q;
    logic [TPS_W-1:0] tps_q;

    // Results still owed by the block, oldest first.
    t_result          owed_results [$];
    t_result          want;
    t_result          got;
    int               fail_total = 0;
    int               results_seen = 0;

    assign o_fail_count = fail_total;

    // Command or status code as formed by the current lines and select.
    function automatic logic [3:0] line_code();
        return {lines_q[LINE_CA1], lines_q[0], select_q, lines_q[LINE_CA2]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_total++;
    endtask

    task automatic check_field(input string name, input int expected_val, input int got_val);
        if (expected_val != got_val) begin
            report_mismatch($sformatf("result %0d %s expected %0d got %0d",
                                      results_seen, name, expected_val, got_val));
        end
    endtask

    // Apply one bus access to the shadow state and form its result.
    task automatic predict_bus_access(input logic [2:0] mode, input t_item it,
                                      output t_result res);
        logic [3:0]       old_lines;
        logic [3:0]       code;
        logic             d;
        logic             status;
        logic             reload;
        logic [RPM_W-1:0] rpm;
        logic [31:0]      acc;

        d      = chosen_q;
        status = 1'b1;
        reload = 1'b0;
        case (mode)
            MODE_LINES: begin
                old_lines = lines_q;
                lines_q   = it.line_bits;
                code      = line_code();
                // A rising strobe runs a command on the enabled drive.
                if (lines_q[LINE_STROBE] && !old_lines[LINE_STROBE] && enabled_q) begin
                    case (code)
                        CMD_DIR_IN:    drive_q[d].step_out = 1'b0;
                        CMD_DIR_OUT:   drive_q[d].step_out = 1'b1;
                        CMD_CLR_SWTCH: drive_q[d].switched = 1'b0;
                        CMD_STEP: begin
                            if (drive_q[d].present) begin
                                if (drive_q[d].step_out) begin
                                    if (drive_q[d].track != 0) begin
                                        drive_q[d].track = drive_q[d].track - 1'b1;
                                    end
                                end else if (int'(drive_q[d].track) + 1 < TRACKS) begin
                                    drive_q[d].track = drive_q[d].track + 1'b1;
                                end
                                reload = 1'b1;
                            end
                        end
                        CMD_MOTOR_ON:  if (drive_q[d].present) drive_q[d].motor = 1'b1;
                        CMD_MOTOR_OFF: if (drive_q[d].present) drive_q[d].motor = 1'b0;
                        CMD_EJECT: begin
                            if (drive_q[d].present) begin
                                drive_q[d] = '0;
                                reload     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            MODE_ENABLE: begin
                if (it.en_code == EN_DRIVE0) begin
                    enabled_q = 1'b1;
                    chosen_q  = 1'b0;
                end else if (it.en_code == EN_DRIVE1 && DRIVES >= 2) begin
                    enabled_q = 1'b1;
                    chosen_q  = 1'b1;
                end else begin
                    enabled_q = 1'b0;
                end
            end
            MODE_SELECT: select_q = it.select_level;
            MODE_STATUS: begin
                code = line_code();
                // CA1 with strobe high, or no enabled drive, reads as one.
                if (!(lines_q[LINE_CA1] && lines_q[LINE_STROBE]) && enabled_q) begin
                    case (code)
                        ST_DIRECTION:  status = drive_q[d].step_out;
                        ST_HEAD_LOWER: begin
                            if (drive_q[d].upper_head) begin
                                drive_q[d].upper_head = 1'b0;
                                reload = 1'b1;
                            end
                            status = 1'b0;
                        end
                        ST_NO_DISK:    status = !drive_q[d].present;
                        ST_HEAD_UPPER: begin
                            if (!drive_q[d].upper_head) begin
                                drive_q[d].upper_head = 1'b1;
                                reload = 1'b1;
                            end
                            status = 1'b0;
                        end
                        ST_STEP_DONE:  status = 1'b1;
                        ST_WR_ENABLED: status = drive_q[d].present && !drive_q[d].protect;
                        ST_MOTOR:      status = drive_q[d].present && drive_q[d].motor;
                        ST_TWO_SIDED:  status = drive_q[d].present ? drive_q[d].two_sided : 1'b1;
                        ST_NOT_TRK0:   status = drive_q[d].present && drive_q[d].track != 0;
                        ST_ZERO_B:     status = 1'b0;
                        ST_SWITCHED:   status = drive_q[d].switched;
                        ST_ZERO_D:     status = 1'b0;
                        ST_TACH:       status = tach_phase_q;
                        ST_ZERO_F:     status = 1'b0;
                        default:       status = 1'b1;
                    endcase
                end
            end
            MODE_MEDIA: begin
                if (int'(it.media_drive) < DRIVES) begin
                    if (it.media_inserted) begin
                        drive_q[it.media_drive].present   = 1'b1;
                        drive_q[it.media_drive].protect   = it.media_wp;
                        drive_q[it.media_drive].two_sided = it.media_ds;
                        drive_q[it.media_drive].switched  = 1'b1;
                    end else begin
                        drive_q[it.media_drive] = '0;
                    end
                    if (it.media_drive == chosen_q) reload = 1'b1;
                end
            end
            MODE_TICK: begin
                // Speed from the register, or from the zone of the track.
                if (ext_speed_q) begin
                    rpm = speed_q;
                end else if (!drive_q[d].present) begin
                    rpm = '0;
                end else begin
                    case (drive_q[d].track >> 4)
                        0:       rpm = 10'd500;
                        1:       rpm = 10'd550;
                        2:       rpm = 10'd600;
                        3:       rpm = 10'd675;
                        default: rpm = 10'd750;
                    endcase
                end
                acc = 32'(tach_acc_q) + 32'(rpm) * 2;
                if (acc >= 32'(tps_q)) begin
                    acc          = acc - 32'(tps_q);
                    tach_phase_q = !tach_phase_q;
                end
                tach_acc_q = acc[TPS_W-1:0];
            end
            default: ;
        endcase

        res              = '0;
        res.status_bit   = status;
        res.track_now    = drive_q[chosen_q].track;
        res.head_now     = drive_q[chosen_q].upper_head;
        res.drive_on     = enabled_q;
        res.drive_chosen = chosen_q;
        res.reload_track = reload;
    endtask

    // Register writes, result comparison and prediction, once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lines_q      = '0;
            enabled_q    = 1'b0;
            chosen_q     = 1'b0;
            select_q     = 1'b0;
            drive_q[0]   = '0;
            drive_q[1]   = '0;
            tach_acc_q   = '0;
            tach_phase_q = 1'b0;
            ext_speed_q  = 1'b0;
            speed_q      = '0;
            tps_q        = TPS_RESET;
            owed_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_EXT_SPEED:   ext_speed_q = i_cfg_wdata[0];
                    CFG_SPEED_VALUE: speed_q     = i_cfg_wdata[RPM_W-1:0];
                    CFG_TICKS_PER_S: tps_q       = i_cfg_wdata[TPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_result)-1:0];
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %h with nothing owed", i_m_tdata));
                end else begin
                    want = owed_results.pop_front();
                    check_field("status_bit", int'(want.status_bit), int'(got.status_bit));
                    check_field("track_now", int'(want.track_now), int'(got.track_now));
                    check_field("head_now", int'(want.head_now), int'(got.head_now));
                    check_field("drive_on", int'(want.drive_on), int'(got.drive_on));
                    check_field("drive_chosen", int'(want.drive_chosen),
                                int'(got.drive_chosen));
                    check_field("reload_track", int'(want.reload_track),
                                int'(got.reload_track));
                end
                results_seen++;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_bus_access(i_s_tuser, t_item'(i_s_tdata[$bits(t_item)-1:0]), want);
                owed_results.push_back(want);
            end
        end
        o_pending <= owed_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the floppy phase register block
// Drives bus access beats with random gaps and output stalls through several
// register settings; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    import fdpri_pkg::*;

    localparam int BEATS_PER_PHASE = 195;
    localparam int IDLE_LIMIT      = 5000;
    localparam int TAIL_CYCLES     = 10;
    localparam int ITEM_W          = $bits(t_item);

    // Codes not named by the package.
    localparam logic [2:0]           MODE_SPARE_LO = 3'd6;
    localparam logic [2:0]           MODE_SPARE_HI = 3'd7;
    localparam logic [1:0]           EN_NONE       = 2'd0;
    localparam logic [1:0]           EN_BOTH       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata     = '0;
    logic [TUSER_W-1:0]   s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    int fail_count;
    int pending_count;
    int idle_cycles  = 0;
    int beats_sent   = 0;
    int ready_left   = 0;
    int stall_len;
    bit calm         = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    floppy_drive_phase_register_interface i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    fdpri_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Idle length: mostly none or short, now and then long; none when calm.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Phase line pattern that forms a given command or status code.
    function automatic logic [3:0] code_lines(input logic [3:0] code, input logic strobe);
        return {strobe, code[0], code[3], code[2]};
    endfunction

    // Output side stalls.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left = ready_left - 1;
        end else if (!m_tready) begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(0, 12);
        end else begin
            stall_len = rand_gap();
            if (stall_len > 0) begin
                m_tready   <= 1'b0;
                ready_left = stall_len - 1;
            end
        end
    end

    // Watchdog on cycles without any beat on either channel.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One input beat, after a random gap; valid stays high for a following beat.
    task automatic send_beat(input logic [2:0] mode, input t_item it);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(TDATA_W - $bits(t_item)){1'b0}}, it};
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    // Beats whose unused payload bits are random.
    task automatic send_plain(input logic [2:0] mode);
        t_item it;
        it = ITEM_W'($urandom_range(0, 2047));
        send_beat(mode, it);
    endtask

    task automatic send_lines(input logic [3:0] bits);
        t_item it;
        it = ITEM_W'($urandom_range(0, 2047));
        it.line_bits = bits;
        send_beat(MODE_LINES, it);
    endtask

    task automatic send_enable(input logic [1:0] mask);
        t_item it;
        it = ITEM_W'($urandom_range(0, 2047));
        it.en_code = mask;
        send_beat(MODE_ENABLE, it);
    endtask

    task automatic send_select(input logic level);
        t_item it;
        it = ITEM_W'($urandom_range(0, 2047));
        it.select_level = level;
        send_beat(MODE_SELECT, it);
    endtask

    task automatic send_media(input logic drv, input logic ins, input logic wp, input logic ds);
        t_item it;
        it = ITEM_W'($urandom_range(0, 2047));
        it.media_drive    = drv;
        it.media_inserted = ins;
        it.media_wp       = wp;
        it.media_ds       = ds;
        send_beat(MODE_MEDIA, it);
    endtask

    // Select, lines with strobe low, then the strobe rising edge.
    task automatic run_strobe_command(input logic [3:0] code);
        send_select(code[1]);
        send_lines(code_lines(code, 1'b0));
        send_lines(code_lines(code, 1'b1));
    endtask

    task automatic read_status_code(input logic [3:0] code, input logic strobe);
        send_select(code[1]);
        send_lines(code_lines(code, strobe));
        send_plain(MODE_STATUS);
    endtask

    // Set a direction, then a run of step pulses.
    task automatic seek_tracks(input int steps, input logic outward);
        run_strobe_command(outward ? CMD_DIR_OUT : CMD_DIR_IN);
        repeat (steps) begin
            send_lines(code_lines(CMD_STEP, 1'b0));
            send_lines(code_lines(CMD_STEP, 1'b1));
        end
    endtask

    // Stop sending and wait for every owed result beat.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // New register setting, only once the block has gone idle.
    task automatic apply_settings(input logic ext, input logic [RPM_W-1:0] spd,
                                  input logic [TPS_W-1:0] tps);
        drain_results();
        write_register(CFG_EXT_SPEED, CFG_W'(ext));
        write_register(CFG_SPEED_VALUE, CFG_W'(spd));
        write_register(CFG_TICKS_PER_S, CFG_W'(tps));
        write_register(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed access sequences, with some raw noise.
    task automatic random_traffic(input int count);
        int goal;
        int pick;
        int r;
        goal = beats_sent + count;
        while (beats_sent < goal) begin
            if ($urandom_range(0, 11) == 0) calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                run_strobe_command(4'($urandom_range(0, 15)));
            end else if (pick < 45) begin
                read_status_code(4'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);
            end else if (pick < 60) begin
                seek_tracks($urandom_range(1, 40), $urandom_range(0, 3) == 0);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 30)) send_plain(MODE_TICK);
            end else if (pick < 77) begin
                r = $urandom_range(0, 9);
                if (r < 4)      send_enable(EN_DRIVE0);
                else if (r < 8) send_enable(EN_DRIVE1);
                else if (r < 9) send_enable(EN_NONE);
                else            send_enable(EN_BOTH);
            end else if (pick < 85) begin
                send_media(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                send_plain(3'($urandom_range(0, 7)));
            end else begin
                drain_results();
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apply_settings(1'b0, 10'd0, TPS_RESET);

        // Directed part: disabled reads, saturation, head switching, eject.
        send_plain(MODE_STATUS);
        send_enable(EN_BOTH);
        send_enable(EN_DRIVE0);
        send_media(1'b0, 1'b1, 1'b1, 1'b1);
        send_media(1'b1, 1'b1, 1'b0, 1'b0);
        run_strobe_command(CMD_DIR_OUT);
        // Stepping outward from track zero stays at zero.
        send_lines(code_lines(CMD_STEP, 1'b0));
        send_lines(code_lines(CMD_STEP, 1'b1));
        read_status_code(ST_HEAD_UPPER, 1'b0);
        send_plain(MODE_STATUS);
        // CA1 together with strobe forces the status bit high.
        send_lines(code_lines(ST_NOT_TRK0, 1'b1));
        send_plain(MODE_STATUS);
        send_plain(MODE_SPARE_LO);
        send_plain(MODE_SPARE_HI);
        send_plain(MODE_TICK);
        send_enable(EN_DRIVE1);
        run_strobe_command(CMD_EJECT);
        send_enable(EN_NONE);
        send_media(1'b1, 1'b0, 1'b1, 1'b1);

        random_traffic(BEATS_PER_PHASE);
        apply_settings(1'b1, 10'd1023, 16'd2048);
        random_traffic(BEATS_PER_PHASE);
        apply_settings(1'b0, 10'd512, 16'd65535);
        random_traffic(BEATS_PER_PHASE);
        apply_settings(1'b1, 10'($urandom_range(0, 1023)), 16'($urandom_range(2048, 65535)));
        random_traffic(BEATS_PER_PHASE);
        apply_settings(1'b1, 10'd0, 16'd2048);
        random_traffic(BEATS_PER_PHASE);
        apply_settings(1'b0, 10'($urandom_range(0, 1023)), 16'd2048);
        random_traffic(BEATS_PER_PHASE);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
